// File: hdl/dlecrc_pkg.sv
// ----------------------------------------------------------------------------
// dlecrc_pkg
// Shared types, symbols, result codes and the CRC-16 byte update for the
// DLE-framed CRC-16 receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package dlecrc_pkg;

  typedef logic [2:0] kind_t;

  // framing symbols
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_SYN = 8'h16;
  localparam logic [7:0] SYM_ETX = 8'h03;

  // result kinds
  localparam kind_t KIND_NONE     = 3'd0;
  localparam kind_t KIND_BYTE     = 3'd1;
  localparam kind_t KIND_GOOD     = 3'd2;
  localparam kind_t KIND_CRCERR   = 3'd3;
  localparam kind_t KIND_OVERFLOW = 3'd4;
  localparam kind_t KIND_RESTART  = 3'd5;

  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic [8:0] frame_length;
  } result_t;

  // MSB-first CRC-16, one byte folded in
  function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/dlecrc_if.sv
// ----------------------------------------------------------------------------
// dlecrc channel interfaces
// Valid/ready channels for received bytes, results and the polynomial write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlecrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dlecrc_result_if
  import dlecrc_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_t      kind;
  logic [8:0] frame_length;
  modport source (output valid, output out_byte, output kind, output frame_length,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input frame_length,
                  output ready);
endinterface

interface dlecrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_polynomial;
  modport source (output valid, output crc_polynomial, input ready);
  modport sink   (input valid, input crc_polynomial, output ready);
endinterface

`default_nettype wire

// File: hdl/dlecrc_in_stage.sv
// ----------------------------------------------------------------------------
// dlecrc_in_stage
// Input register: holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dlecrc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_ready,
  input  wire logic       out_can_load,
  output logic            hold_valid,
  output logic [7:0]      hold_byte,
  output logic            advance
);

  assign advance  = hold_valid && out_can_load;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dlecrc_core.sv
// ----------------------------------------------------------------------------
// dlecrc_core
// Frame state, DLE unstuffing, CRC-16 and length count; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dlecrc_core
  import dlecrc_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] poly,
  output result_t          res
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    PH_HUNT_DLE = 3'd0,
    PH_HUNT_SYN = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_CRC_HI   = 3'd3,
    PH_CRC_LO   = 3'd4
  } phase_t;

  phase_t             phase, phase_next;
  logic               esc, esc_next;
  logic [15:0]        crc, crc_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [15:0]        crc_fb;
  logic [CNT_W-1:0]   len_src;
  logic [CNT_W+8:0]   len_wide;

  assign crc_fb = crc_fold(crc, rx_byte, poly);

  always_comb begin
    phase_next   = phase;
    esc_next     = esc;
    crc_next     = crc;
    count_next   = count;
    res.out_byte = 8'h00;
    res.kind     = KIND_NONE;
    len_src      = count;
    if (count == CNT_W'(MAX_LEN)) begin
      // byte dropped, full count reported
      phase_next = PH_HUNT_DLE;
      esc_next   = 1'b0;
      count_next = '0;
      res.kind   = KIND_OVERFLOW;
    end else begin
      case (phase)
        PH_HUNT_SYN: begin
          if (rx_byte == SYM_SYN) begin
            crc_next   = '0;
            count_next = '0;
            esc_next   = 1'b0;
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = PH_HUNT_DLE;
          end
        end
        PH_PAYLOAD: begin
          if (!esc) begin
            if (rx_byte == SYM_DLE) begin
              esc_next = 1'b1;
            end else begin
              crc_next     = crc_fb;
              count_next   = count + CNT_W'(1);
              res.kind     = KIND_BYTE;
              res.out_byte = rx_byte;
            end
          end else begin
            esc_next = 1'b0;
            if (rx_byte == SYM_DLE) begin
              crc_next     = crc_fb;
              count_next   = count + CNT_W'(1);
              res.kind     = KIND_BYTE;
              res.out_byte = rx_byte;
            end else if (rx_byte == SYM_SYN) begin
              count_next = '0;
              crc_next   = '0;
              res.kind   = KIND_RESTART;
            end else if (rx_byte == SYM_ETX) begin
              phase_next = PH_CRC_HI;
            end else begin
              phase_next = PH_HUNT_DLE;
            end
          end
        end
        PH_CRC_HI: begin
          crc_next   = crc_fb;
          phase_next = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_next   = crc_fb;
          res.kind   = (crc_fb == 16'h0000) ? KIND_GOOD : KIND_CRCERR;
          phase_next = PH_HUNT_DLE;
        end
        default: begin
          // hunting, also unused phase codes
          phase_next = (rx_byte == SYM_DLE) ? PH_HUNT_SYN : PH_HUNT_DLE;
        end
      endcase
      len_src = count_next;
    end
    // frame_length carries the low 9 bits of the count
    len_wide         = {9'd0, len_src};
    res.frame_length = len_wide[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT_DLE;
      esc   <= 1'b0;
      crc   <= '0;
      count <= '0;
    end else if (step) begin
      phase <= phase_next;
      esc   <= esc_next;
      crc   <= crc_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dlecrc_out_stage.sv
// ----------------------------------------------------------------------------
// dlecrc_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dlecrc_out_stage
  import dlecrc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         can_load,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dle_frame_crc16_receiver_top.sv
// ----------------------------------------------------------------------------
// dle_frame_crc16_receiver_top
// Receiver for DLE byte-stuffed frames with CRC-16 check, one result per byte.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                          Transfer
//  rx       in   rx_byte[7:0]                     valid & ready
//  res      out  out_byte[7:0] kind[2:0]          valid & ready
//                frame_length[8:0]
//  cfg      in   crc_polynomial[15:0]             valid & ready (always ready)
//
//  res valid rises after the rx byte passes the input register, then the
//  frame/CRC update into the result register. One byte per cycle unless res stalls.
//  The CRC byte update (eight shift/xor steps) sets the cycle's logic depth.
//  Reset clears frame state, count and CRC, and loads polynomial 0x1021.
//  A stalled res holds its result and backs up into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_frame_crc16_receiver_top
  import dlecrc_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  dlecrc_byte_if.sink     rx,
  dlecrc_result_if.source res,
  dlecrc_cfg_if.sink      cfg
);

  localparam logic [8:0] MAX_LEN_LO = 9'(MAX_LEN);

  logic [15:0] poly;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        advance;
  logic        can_load;
  result_t     core_res;
  result_t     out_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= CRC_POLY_RESET;
    end else if (cfg.valid) begin
      poly <= cfg.crc_polynomial;
    end
  end

  dlecrc_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rx.valid),
    .in_byte      (rx.rx_byte),
    .in_ready     (rx.ready),
    .out_can_load (can_load),
    .hold_valid   (hold_valid),
    .hold_byte    (hold_byte),
    .advance      (advance)
  );

  dlecrc_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (hold_byte),
    .poly    (poly),
    .res     (core_res)
  );

  dlecrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (core_res),
    .can_load  (can_load),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .res_out   (out_res)
  );

  assign res.out_byte     = out_res.out_byte;
  assign res.kind         = out_res.kind;
  assign res.frame_length = out_res.frame_length;

  // a held byte is never dropped while the result side is stalled
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid)
    else $error("held input byte lost");

  // data byte is only nonzero on a payload result
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind != KIND_BYTE) |-> res.out_byte == 8'h00)
    else $error("out_byte set on non-payload result");

  // overflow always reports the full length
  a_ovf_len: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == KIND_OVERFLOW) |-> res.frame_length == MAX_LEN_LO)
    else $error("overflow with wrong length");

  // result register only loads when it is free or being emptied
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(out_res))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
